FILE: src/sss_pkg.sv
// Shared constants and types of the sample set statistics block.
`default_nettype none

package sss_pkg;

   localparam int MAX_SAMPLES = 128;
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_OUT_W = 8;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int LOG_MAX     = $clog2(MAX_SAMPLES);
   localparam int SUM_W       = SAMPLE_W + LOG_MAX;
   localparam int SQR_W       = 2 * SAMPLE_W - 1;
   localparam int SQ_W        = SQR_W + LOG_MAX;
   localparam int NUM_RAW_W   = SQR_W + 2 * LOG_MAX;
   localparam int NUM_W       = NUM_RAW_W + (NUM_RAW_W % 2);
   localparam int RT_W        = NUM_W / 2;
   localparam int DSR_W       = 2 * CNT_W;
   localparam int AW          = NUM_W + 2;
   localparam int STEP_W      = $clog2(NUM_W);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SAMPLE_W-1:0]        ufield_type;
   typedef logic [COUNT_OUT_W-1:0]     count_field_type;

endpackage

`default_nettype wire

FILE: src/sss_if.sv
// Handshake channels for the sample words and the statistics words.
`default_nettype none

interface sss_req_if;
   import sss_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface sss_rsp_if;
   import sss_pkg::*;

   logic            valid;
   logic            ready;
   sample_type      maximum;
   sample_type      minimum;
   sample_type      mean_value;
   ufield_type      std_dev;
   ufield_type      spread;
   count_field_type sample_count;
   logic            overflowed;

   modport source (output valid, output maximum, output minimum, output mean_value,
                   output std_dev, output spread, output sample_count,
                   output overflowed, input ready);
   modport sink (input valid, input maximum, input minimum, input mean_value,
                 input std_dev, input spread, input sample_count,
                 input overflowed, output ready);
endinterface

`default_nettype wire

FILE: src/sample_set_statistics.sv
// Running statistics over a set of Q8.8 samples with a shared add/subtract unit.
//
//   channel   direction   carries
//   req_ch    in          sample, last
//   rsp_ch    out         maximum, minimum, mean_value, std_dev, spread,
//                         sample_count, overflowed
//
// A sample word that does not close the set is taken while the block is idle.
// The closing word holds the input while the one add/subtract unit does the
// products, both divisions and the square root a bit or a bit pair at a time.
// Reset clears the sums, the count and the output valid.
// A stalled result word holds the block in its final step only.
`default_nettype none

module sample_set_statistics (
   input  logic    clock,
   input  logic    reset,
   sss_req_if.sink   req_ch,
   sss_rsp_if.source rsp_ch
);
   import sss_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NSQ,
      ST_NS2,
      ST_S1SQ,
      ST_DIFF,
      ST_VDIV,
      ST_ROOT,
      ST_MDIV,
      ST_FIN
   } state_type;

   state_type                state_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [SAMPLE_W-1:0] max_ff, min_ff, max_in, min_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     drop_ff, drop_in;

   logic [AW-1:0]            acc_ff;
   logic [NUM_W-1:0]         opa_ff;
   logic [NUM_W-1:0]         mq_ff;
   logic [NUM_W-1:0]         tmp_ff;
   logic [DSR_W-1:0]         dsr_ff;
   logic [RT_W-1:0]          root_ff;
   logic [SAMPLE_W-1:0]      sd_ff;

   logic                     rsp_valid_ff;
   sample_type               max_out_ff, min_out_ff, mean_out_ff;
   ufield_type               sd_out_ff, spread_out_ff;
   count_field_type          cnt_out_ff;
   logic                     drop_out_ff;

   logic signed [2*SAMPLE_W-1:0] sq_prod;
   logic [SUM_W-1:0]         abs_sum;
   logic [SUM_W-1:0]         mean_full;
   logic [AW-1:0]            alu_a, alu_b, alu_res;
   logic                     alu_sub, alu_ge;
   logic [AW:0]              alu_sum;
   logic [RT_W-1:0]          root_next;

   // Accumulation of one sample word.
   assign sq_prod = req_ch.sample * req_ch.sample;

   always_comb begin
      max_in  = max_ff;
      min_in  = min_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      cnt_in  = cnt_ff;
      drop_in = drop_ff;
      if (cnt_ff < CNT_W'(MAX_SAMPLES)) begin
         if (cnt_ff == '0) begin
            max_in = req_ch.sample;
            min_in = req_ch.sample;
         end else begin
            if (req_ch.sample > max_ff) max_in = req_ch.sample;
            if (req_ch.sample < min_ff) min_in = req_ch.sample;
         end
         sum_in = sum_ff + {{(SUM_W-SAMPLE_W){req_ch.sample[SAMPLE_W-1]}}, req_ch.sample};
         sq_in  = sq_ff + {{(SQ_W-SQR_W){1'b0}}, sq_prod[SQR_W-1:0]};
         cnt_in = cnt_ff + 1'b1;
      end else begin
         drop_in = 1'b1;
      end
   end

   assign abs_sum   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mean_full = sum_ff[SUM_W-1] ? SUM_W'(-mq_ff[SUM_W-1:0]) : mq_ff[SUM_W-1:0];

   // Operand selection for the shared add/subtract unit.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_NSQ, ST_NS2, ST_S1SQ: begin
            alu_a = {acc_ff[AW-2:0], 1'b0};
            alu_b = mq_ff[NUM_W-1] ? AW'(opa_ff) : '0;
         end
         ST_DIFF: begin
            alu_a   = AW'(tmp_ff);
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         ST_VDIV: begin
            alu_a   = {acc_ff[AW-2:0], mq_ff[NUM_W-1]};
            alu_b   = AW'(dsr_ff);
            alu_sub = 1'b1;
         end
         ST_ROOT: begin
            alu_a   = {acc_ff[AW-3:0], mq_ff[NUM_W-1 -: 2]};
            alu_b   = AW'({root_ff, 2'b01});
            alu_sub = 1'b1;
         end
         ST_MDIV: begin
            alu_a   = {acc_ff[AW-2:0], mq_ff[NUM_W-1]};
            alu_b   = AW'(cnt_ff);
            alu_sub = 1'b1;
         end
         ST_IDLE, ST_FIN: begin
            alu_a = '0;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
   assign alu_res   = alu_sum[AW-1:0];
   assign alu_ge    = alu_sum[AW];
   assign root_next = {root_ff[RT_W-2:0], alu_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_ff       <= '0;
         min_ff       <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  max_ff  <= max_in;
                  min_ff  <= min_in;
                  sum_ff  <= sum_in;
                  sq_ff   <= sq_in;
                  cnt_ff  <= cnt_in;
                  drop_ff <= drop_in;
                  if (req_ch.last) begin
                     state_ff <= ST_NSQ;
                     acc_ff   <= '0;
                     opa_ff   <= NUM_W'(cnt_in);
                     mq_ff    <= {cnt_in, {(NUM_W-CNT_W){1'b0}}};
                     step_ff  <= STEP_W'(CNT_W - 1);
                  end
               end
            end
            ST_NSQ, ST_NS2, ST_S1SQ: begin
               if (step_ff == '0) begin
                  if (state_ff == ST_NSQ) begin
                     dsr_ff   <= alu_res[DSR_W-1:0];
                     state_ff <= ST_NS2;
                     acc_ff   <= '0;
                     opa_ff   <= NUM_W'(sq_ff);
                     mq_ff    <= {cnt_ff, {(NUM_W-CNT_W){1'b0}}};
                     step_ff  <= STEP_W'(CNT_W - 1);
                  end else if (state_ff == ST_NS2) begin
                     tmp_ff   <= alu_res[NUM_W-1:0];
                     state_ff <= ST_S1SQ;
                     acc_ff   <= '0;
                     opa_ff   <= NUM_W'(abs_sum);
                     mq_ff    <= {abs_sum, {(NUM_W-SUM_W){1'b0}}};
                     step_ff  <= STEP_W'(SUM_W - 1);
                  end else begin
                     acc_ff   <= alu_res;
                     state_ff <= ST_DIFF;
                  end
               end else begin
                  acc_ff  <= alu_res;
                  mq_ff   <= {mq_ff[NUM_W-2:0], 1'b0};
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_DIFF: begin
               mq_ff    <= alu_res[NUM_W-1:0];
               acc_ff   <= '0;
               step_ff  <= STEP_W'(NUM_W - 1);
               state_ff <= ST_VDIV;
            end
            ST_VDIV: begin
               mq_ff <= {mq_ff[NUM_W-2:0], alu_ge};
               if (step_ff == '0) begin
                  acc_ff   <= '0;
                  root_ff  <= '0;
                  step_ff  <= STEP_W'(RT_W - 1);
                  state_ff <= ST_ROOT;
               end else begin
                  acc_ff  <= alu_ge ? alu_res : alu_a;
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_ROOT: begin
               root_ff <= root_next;
               if (step_ff == '0) begin
                  sd_ff    <= root_next[SAMPLE_W-1:0];
                  acc_ff   <= '0;
                  mq_ff    <= {abs_sum, {(NUM_W-SUM_W){1'b0}}};
                  step_ff  <= STEP_W'(SUM_W - 1);
                  state_ff <= ST_MDIV;
               end else begin
                  acc_ff  <= alu_ge ? alu_res : alu_a;
                  mq_ff   <= {mq_ff[NUM_W-3:0], 2'b00};
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_MDIV: begin
               acc_ff  <= alu_ge ? alu_res : alu_a;
               mq_ff   <= {mq_ff[NUM_W-2:0], alu_ge};
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  max_out_ff    <= max_ff;
                  min_out_ff    <= min_ff;
                  mean_out_ff   <= mean_full[SAMPLE_W-1:0];
                  sd_out_ff     <= sd_ff;
                  spread_out_ff <= SAMPLE_W'(max_ff - min_ff);
                  cnt_out_ff    <= COUNT_OUT_W'(cnt_ff);
                  drop_out_ff   <= drop_ff;
                  max_ff        <= '0;
                  min_ff        <= '0;
                  sum_ff        <= '0;
                  sq_ff         <= '0;
                  cnt_ff        <= '0;
                  drop_ff       <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.maximum      = max_out_ff;
   assign rsp_ch.minimum      = min_out_ff;
   assign rsp_ch.mean_value   = mean_out_ff;
   assign rsp_ch.std_dev      = sd_out_ff;
   assign rsp_ch.spread       = spread_out_ff;
   assign rsp_ch.sample_count = cnt_out_ff;
   assign rsp_ch.overflowed   = drop_out_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count above capacity");

   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.last |=> !req_ch.ready)
      else $error("closing word did not stop the input");

   a_clear_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> cnt_ff == '0 && !drop_ff)
      else $error("accumulators not cleared with the result");

   a_sd_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.std_dev <= rsp_ch.spread)
      else $error("standard deviation exceeds spread");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.minimum <= rsp_ch.maximum)
      else $error("minimum exceeds maximum");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/sample_set_statistics_tb.sv
// Self-checking bench for sample_set_statistics: sample sets checked against a predictor.
`timescale 1ns / 100ps

module sample_set_statistics_tb;
   import sss_pkg::*;

   localparam int RANDOM_WORDS = 1450;
   localparam int CALM_WORDS   = 1250;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      sample_type      maximum;
      sample_type      minimum;
      sample_type      mean_value;
      ufield_type      std_dev;
      ufield_type      spread;
      count_field_type sample_count;
      logic            overflowed;
   } set_stats_type;

   class stats_scoreboard;
      sample_type hi;
      sample_type lo;
      longint     total;
      longint     total_sq;
      int         count;
      bit         dropped;
      set_stats_type pending_q[$];
      int         errors;
      int         checked;

      function new();
         clear();
         errors  = 0;
         checked = 0;
      endfunction

      function void clear();
         hi       = '0;
         lo       = '0;
         total    = 0;
         total_sq = 0;
         count    = 0;
         dropped  = 1'b0;
      endfunction

      function longint floor_root(longint v);
         longint r;
         longint t;
         r = 0;
         for (int b = 20; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
               r = t;
         end
         return r;
      endfunction

      // Accumulates one accepted sample word; a closing word yields the expected statistics.
      function void note_word(sample_type s, logic is_last);
         set_stats_type e;
         longint     n;
         longint     num;
         longint     var_q;
         if (count < MAX_SAMPLES) begin
            if (count == 0) begin
               hi = s;
               lo = s;
            end else begin
               if (s > hi) hi = s;
               if (s < lo) lo = s;
            end
            total    += longint'(s);
            total_sq += longint'(s) * longint'(s);
            count++;
         end else begin
            dropped = 1'b1;
         end
         if (!is_last)
            return;
         n     = count;
         num   = n * total_sq - total * total;
         var_q = num / (n * n);
         e.maximum      = hi;
         e.minimum      = lo;
         e.mean_value   = sample_type'(total / n);
         e.std_dev      = ufield_type'(floor_root(var_q));
         e.spread       = ufield_type'(hi - lo);
         e.sample_count = count_field_type'(count);
         e.overflowed   = dropped;
         pending_q.push_back(e);
         clear();
      endfunction

      function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_word(set_stats_type got);
         set_stats_type want;
         checked++;
         if (pending_q.size() == 0) begin
            $error("statistics word arrived with no set closed: maximum %0d, count %0d",
                   $signed(got.maximum), got.sample_count);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         compare("maximum", $signed(want.maximum), $signed(got.maximum));
         compare("minimum", $signed(want.minimum), $signed(got.minimum));
         compare("mean_value", $signed(want.mean_value), $signed(got.mean_value));
         compare("std_dev", want.std_dev, got.std_dev);
         compare("spread", want.spread, got.spread);
         compare("sample_count", want.sample_count, got.sample_count);
         compare("overflowed", want.overflowed, got.overflowed);
      endfunction
   endclass

   logic            clock;
   logic            reset;
   stats_scoreboard board = new();
   set_stats_type   seen;
   int              words_sent;
   int              cycle_count;
   bit              calm;
   bit              held;

   sss_req_if req_ch ();
   sss_rsp_if rsp_ch ();

   sample_set_statistics u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.maximum      = rsp_ch.maximum;
         seen.minimum      = rsp_ch.minimum;
         seen.mean_value   = rsp_ch.mean_value;
         seen.std_dev      = rsp_ch.std_dev;
         seen.spread       = rsp_ch.spread;
         seen.sample_count = rsp_ch.sample_count;
         seen.overflowed   = rsp_ch.overflowed;
         board.check_word(seen);
      end
   end

   // The long hold lets the result word back up until the closing sample word stalls.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && board.checked >= 12) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   task automatic send_word(sample_type s, logic is_last);
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      req_ch.last   <= is_last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      board.note_word(s, is_last);
      words_sent++;
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      req_ch.valid  <= 1'b0;
      req_ch.sample <= sample_type'($urandom);
      req_ch.last   <= 1'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_set(int len, int flavour, bit gappy);
      sample_type base;
      sample_type s;
      base = sample_type'($urandom);
      for (int i = 0; i < len; i++) begin
         case (flavour)
            0: s = sample_type'($urandom);
            1: begin
               case ($urandom_range(0, 4))
                  0: s = 16'sh7fff;
                  1: s = 16'sh8000;
                  2: s = 16'sh0000;
                  3: s = 16'shffff;
                  default: s = 16'sh0001;
               endcase
            end
            2: s = base + sample_type'($urandom_range(0, 63)) - 16'sd32;
            default: s = base;
         endcase
         send_word(s, i == len - 1);
         if (gappy && !calm && $urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 14));
      end
   endtask

   initial begin
      int rand_start;
      int set_idx;
      int len;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      req_ch.last   <= 1'b0;
      reset         <= 1'b1;
      words_sent    = 0;
      calm          = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Single-sample sets at both extremes, then the widest possible spread.
      send_word(16'sh7fff, 1'b1);
      send_word(16'sh8000, 1'b1);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh7fff, 1'b1);
      // A constant set at the most negative value: zero deviation.
      send_word(16'sh8000, 1'b0);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh8000, 1'b1);
      // A negative mean that must truncate toward zero.
      send_word(-16'sd3, 1'b0);
      send_word(16'sd0, 1'b1);
      // The largest deviation the sample range allows.
      send_word(16'sh7fff, 1'b0);
      send_word(16'sh7fff, 1'b0);
      send_word(16'sh8000, 1'b0);
      send_word(16'sh8000, 1'b1);
      send_word(16'sd5, 1'b0);
      send_word(-16'sd7, 1'b0);
      send_word(16'sd100, 1'b0);
      send_word(16'sh0100, 1'b0);
      send_word(-16'sd1, 1'b1);

      // Every twentieth set runs near or past capacity; the first of these closes on a
      // dropped sample, a later one fills the capacity exactly.
      rand_start = words_sent;
      set_idx    = 0;
      while (words_sent - rand_start < RANDOM_WORDS) begin
         if (words_sent - rand_start >= CALM_WORDS)
            calm = 1'b1;
         if (set_idx == 3)
            len = MAX_SAMPLES + 3;
         else if (set_idx == 23)
            len = MAX_SAMPLES;
         else if (set_idx % 20 == 3)
            len = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 12);
         else if ($urandom_range(0, 7) == 0)
            len = $urandom_range(17, 64);
         else
            len = $urandom_range(1, 16);
         send_set(len, $urandom_range(0, 3), $urandom_range(0, 1));
         set_idx++;
      end
      pause_sender(1);

      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
